@@ src/mhpq_pkg.sv @@
// Shared types and constants for the binary max-heap priority queue.
// Used by max_heap_priority_queue; no dependencies of its own.
package mhpq_pkg;

  localparam int HEAP_DEPTH = 64;
  localparam int KEY_WIDTH  = 32;
  localparam int IDX_W      = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
  // Child positions reach 2*(HEAP_DEPTH-1)+2, so they need one bit more than a count.
  localparam int CHILD_W    = CNT_W + 1;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_EXTRACT  = 2'd1,
    OP_INCREASE = 2'd2,
    OP_NOP      = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_SMALLER  = 3'd3,
    ST_BADINDEX = 3'd4
  } status_t;

  typedef struct packed {
    op_t                         op;
    logic signed [KEY_WIDTH-1:0] key;
    logic [IDX_W-1:0]            entry_index;
  } req_t;

  typedef struct packed {
    logic signed [KEY_WIDTH-1:0] result_value;
    status_t                     status;
    logic [CNT_W-1:0]            entry_count;
    logic                        top_valid;
    logic signed [KEY_WIDTH-1:0] top_value;
  } rsp_t;

endpackage

@@ src/mhpq_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ src/max_heap_priority_queue.sv @@
// Binary max-heap priority queue; keys live in one RAM (mhpq_ram), uses mhpq_pkg.
// Each item is taken only in idle and finishes before the next is accepted: insert sifts
// the new key up one level at a time, increase checks the raise and then sifts up, extract
// moves the last entry to the root and sifts it down; full, empty, bad-index, no-op and
// last-entry items and a too-small raise move no keys. A held result beat stalls the input.
// Reset clears the entry count; the key RAM is not cleared and needs no sweep.
module max_heap_priority_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  mhpq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output mhpq_pkg::rsp_t rsp
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_INC_CMP  = 9'b000000010,
    S_UP_CMP   = 9'b000000100,
    S_EXT_LAST = 9'b000001000,
    S_DN_RD_L  = 9'b000010000,
    S_DN_RD_R  = 9'b000100000,
    S_DN_CMP   = 9'b001000000,
    S_FIN      = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  state_t                                state, state_next;
  logic [mhpq_pkg::IDX_W-1:0]            pos, pos_next;
  logic signed [mhpq_pkg::KEY_WIDTH-1:0] cur, cur_next;
  logic signed [mhpq_pkg::KEY_WIDTH-1:0] left_key, left_key_next;
  logic                                  has_r, has_r_next;
  logic [mhpq_pkg::CNT_W-1:0]            cnt, cnt_next;
  logic signed [mhpq_pkg::KEY_WIDTH-1:0] res_val, res_val_next;
  mhpq_pkg::status_t                     stat, stat_next;
  logic signed [mhpq_pkg::KEY_WIDTH-1:0] top_key;

  logic                                  wr_en;
  logic [mhpq_pkg::IDX_W-1:0]            wr_addr;
  logic signed [mhpq_pkg::KEY_WIDTH-1:0] wr_data;
  logic [mhpq_pkg::IDX_W-1:0]            rd_addr;
  logic [mhpq_pkg::KEY_WIDTH-1:0]        rd_data;
  logic signed [mhpq_pkg::KEY_WIDTH-1:0] rd_key;

  logic [mhpq_pkg::IDX_W-1:0]            parent, grand, ins_parent;
  logic [mhpq_pkg::CHILD_W-1:0]          l_idx, r_idx, n_ext;
  logic                                  take_l, take_r, rsp_free;
  logic signed [mhpq_pkg::KEY_WIDTH-1:0] big_key;

  mhpq_ram #(
    .WIDTH(mhpq_pkg::KEY_WIDTH),
    .DEPTH(mhpq_pkg::HEAP_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign rd_key     = rd_data;
  assign parent     = (pos - mhpq_pkg::IDX_W'(1)) >> 1;
  assign grand      = (parent - mhpq_pkg::IDX_W'(1)) >> 1;
  assign ins_parent = mhpq_pkg::IDX_W'((cnt - mhpq_pkg::CNT_W'(1)) >> 1);
  assign l_idx      = mhpq_pkg::CHILD_W'({pos, 1'b1});
  assign r_idx      = l_idx + mhpq_pkg::CHILD_W'(1);
  assign n_ext      = mhpq_pkg::CHILD_W'(cnt);
  assign take_l     = left_key > cur;
  assign big_key    = take_l ? left_key : cur;
  assign take_r     = has_r && (rd_key > big_key);
  assign rsp_free   = !rsp_valid || rsp_ready;
  assign req_ready  = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    pos_next      = pos;
    cur_next      = cur;
    left_key_next = left_key;
    has_r_next    = has_r;
    cnt_next      = cnt;
    res_val_next  = res_val;
    stat_next     = stat;
    wr_en         = 1'b0;
    wr_addr       = pos;
    wr_data       = cur;
    rd_addr       = parent;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cur_next     = req.key;
          res_val_next = '0;
          stat_next    = mhpq_pkg::ST_OK;
          state_next   = S_DONE;
          case (req.op)
            mhpq_pkg::OP_INSERT: begin
              if (cnt == mhpq_pkg::CNT_W'(mhpq_pkg::HEAP_DEPTH)) begin
                stat_next = mhpq_pkg::ST_FULL;
              end else begin
                pos_next = cnt[mhpq_pkg::IDX_W-1:0];
                cnt_next = cnt + mhpq_pkg::CNT_W'(1);
                if (cnt == '0) begin
                  state_next = S_FIN;
                end else begin
                  rd_addr    = ins_parent;
                  state_next = S_UP_CMP;
                end
              end
            end
            mhpq_pkg::OP_EXTRACT: begin
              if (cnt == '0) begin
                stat_next = mhpq_pkg::ST_EMPTY;
              end else begin
                res_val_next = top_key;
                cnt_next     = cnt - mhpq_pkg::CNT_W'(1);
                rd_addr      = mhpq_pkg::IDX_W'(cnt - mhpq_pkg::CNT_W'(1));
                if (cnt != mhpq_pkg::CNT_W'(1)) begin
                  state_next = S_EXT_LAST;
                end
              end
            end
            mhpq_pkg::OP_INCREASE: begin
              if (mhpq_pkg::CNT_W'(req.entry_index) >= cnt) begin
                stat_next = mhpq_pkg::ST_BADINDEX;
              end else begin
                rd_addr    = req.entry_index;
                pos_next   = req.entry_index;
                state_next = S_INC_CMP;
              end
            end
            default: begin
              stat_next = mhpq_pkg::ST_OK;
            end
          endcase
        end
      end
      S_INC_CMP: begin
        if (cur < rd_key) begin
          stat_next  = mhpq_pkg::ST_SMALLER;
          state_next = S_DONE;
        end else if (pos == '0) begin
          state_next = S_FIN;
        end else begin
          rd_addr    = parent;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        // The moving key stays in cur; the parent drops into the hole at pos.
        wr_en = 1'b1;
        if (cur > rd_key) begin
          wr_data  = rd_key;
          pos_next = parent;
          rd_addr  = grand;
          if (parent == '0) begin
            state_next = S_FIN;
          end
        end else begin
          state_next = S_DONE;
        end
      end
      S_EXT_LAST: begin
        cur_next   = rd_key;
        pos_next   = '0;
        state_next = S_DN_RD_L;
      end
      S_DN_RD_L: begin
        if (l_idx >= n_ext) begin
          state_next = S_FIN;
        end else begin
          rd_addr    = l_idx[mhpq_pkg::IDX_W-1:0];
          state_next = S_DN_RD_R;
        end
      end
      S_DN_RD_R: begin
        left_key_next = rd_key;
        has_r_next    = r_idx < n_ext;
        rd_addr       = r_idx[mhpq_pkg::IDX_W-1:0];
        state_next    = S_DN_CMP;
      end
      S_DN_CMP: begin
        wr_en = 1'b1;
        if (take_r) begin
          wr_data    = rd_key;
          pos_next   = r_idx[mhpq_pkg::IDX_W-1:0];
          state_next = S_DN_RD_L;
        end else if (take_l) begin
          wr_data    = left_key;
          pos_next   = l_idx[mhpq_pkg::IDX_W-1:0];
          state_next = S_DN_RD_L;
        end else begin
          state_next = S_DONE;
        end
      end
      S_FIN: begin
        wr_en      = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (state == S_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos      <= pos_next;
    cur      <= cur_next;
    left_key <= left_key_next;
    has_r    <= has_r_next;
    res_val  <= res_val_next;
    stat     <= stat_next;
    // Shadow copy of the root so the current maximum is available without a read.
    if (wr_en && wr_addr == '0) begin
      top_key <= wr_data;
    end
    if (state == S_DONE && rsp_free) begin
      rsp.result_value <= res_val;
      rsp.status       <= stat;
      rsp.entry_count  <= cnt;
      rsp.top_valid    <= (cnt != '0);
      rsp.top_value    <= (cnt != '0) ? top_key : '0;
    end
  end

endmodule
